// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the streaming find-and-replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

  // window cells, one per pattern character
  localparam int unsigned MAX_PATTERN     = 8;
  // replacement characters emitted per match at most
  localparam int unsigned MAX_REPLACEMENT = 8;
  // output queue cells, one per result of a single transaction
  localparam int unsigned NUM_RESULTS     = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 4;   // holds 0..15
  localparam int unsigned FILL_W  = 3;   // window fill stays below the pattern length
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CFG_IDX_W = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_output;
  } text_out_t;

  // window cell control, common to the whole row
  typedef struct packed {
    logic write;   // take the current byte (stored or newly placed)
    logic shift;   // take the neighbour's current byte
  } win_ctl_t;

  // output queue control, common to the whole row
  typedef struct packed {
    logic load;    // load a fresh burst of results
    logic shift;   // move every entry one place towards the head
  } oq_ctl_t;

endpackage

// ===== sv/sfr_win_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_win_cell
// one pending byte of the match window with its pattern compare
// ----------------------------------------------------------------------------
module sfr_win_cell import sfr_pkg::*; (
  input  logic              clk_i,
  input  win_ctl_t          ctl_i,
  input  logic              sel_i,        // this cell is the next free slot
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  input  logic              in_use_i,     // cell lies inside the pattern length
  input  logic [BYTE_W-1:0] nbr_i,        // current byte of the next cell
  output logic [BYTE_W-1:0] cur_o,
  output logic              match_o
);

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  // window contents with the incoming byte placed
  assign cur_o   = sel_i ? text_byte_i : byte_q;
  assign match_o = !in_use_i || (cur_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.shift) begin
      byte_d = nbr_i;
    end else if (ctl_i.write) begin
      byte_d = cur_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ===== sv/sfr_out_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_out_cell
// one entry of the result queue, drains towards the head
// ----------------------------------------------------------------------------
module sfr_out_cell import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  oq_ctl_t   ctl_i,
  input  logic      load_occ_i,
  input  text_out_t load_item_i,
  input  logic      nbr_occ_i,
  input  text_out_t nbr_item_i,
  output logic      occ_o,
  output text_out_t item_o
);

  logic      occ_q, occ_d;
  text_out_t item_q, item_d;

  always_comb begin
    occ_d  = occ_q;
    item_d = item_q;
    if (ctl_i.load) begin
      occ_d  = load_occ_i;
      item_d = load_item_i;
    end else if (ctl_i.shift) begin
      occ_d  = nbr_occ_i;
      item_d = nbr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign occ_o  = occ_q;
  assign item_o = item_q;

endmodule

// ===== sv/stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace
// streaming find-and-replace over a byte stream, leftmost non-overlapping
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  -------   ---------------------------------------  ---------
//  text in   in_valid_i  in_ready_o  in_data_i        sink
//  text out  out_valid_o out_ready_i out_data_o       source
//  config    cfg_valid_i cfg_ready_o cfg_index_i      sink
//            cfg_data_i
//
//  an input transaction that yields n results (n from 0 to 8) is followed by
//  the next one only as its results drain: the result queue drains one entry
//  per cycle into the output register while the output is not stalled, and the
//  next transaction is taken once at most the leaving entry remains
//  plain bytes that cause a single result therefore stream at one per cycle while the output is not stalled
//  reset is asynchronous and active low; no clearing pass is needed
//  an output stall holds the output register, and one further transaction
//  is still taken into the queue behind it
//
module stream_find_replace import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // text in
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  text_in_t             in_data_i,
  // text out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output text_out_t            out_data_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  // configuration registers
  logic [WORD_W-1:0] pat_bytes_q;
  logic [LEN_W-1:0]  pat_len_q;
  logic [WORD_W-1:0] rep_bytes_q;
  logic [LEN_W-1:0]  rep_len_q;

  // window control
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  fill_ext;

  // window row
  logic [BYTE_W-1:0] cur    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0] cell_sel;
  logic [MAX_PATTERN-1:0] cell_in_use;
  win_ctl_t          win_ctl;

  // result queue row
  logic [NUM_RESULTS-1:0] occ;
  text_out_t         item     [NUM_RESULTS];
  text_out_t         load_item[NUM_RESULTS];
  logic [NUM_RESULTS-1:0] load_occ;
  oq_ctl_t           oq_ctl;

  // output register
  logic      out_valid_q, out_valid_d;
  text_out_t out_q, out_d;

  logic in_acc;
  logic cfg_acc;
  logic head_move;
  logic full;
  logic hit;
  logic last;
  logic marker;
  logic [LEN_W-1:0] n_raw;
  logic [LEN_W-1:0] n_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign last        = in_data_i.end_of_text;

  // effective lengths: pattern length zero counts as one, both saturate
  always_comb begin
    if (pat_len_q == '0) begin
      plen = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = pat_len_q;
    end
    if (rep_len_q > LEN_W'(MAX_REPLACEMENT)) begin
      rlen = LEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = rep_len_q;
    end
  end

  assign fill_ext = LEN_W'(fill_q);
  // window holds a full pattern once the incoming byte is placed
  assign full     = (fill_ext + LEN_W'(1)) == plen;
  assign hit      = full && (&cell_match);

  // ---- window row: each cell compares its byte, hands it on when the window slides
  assign win_ctl.write = in_acc;
  assign win_ctl.shift = in_acc && full && !hit;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    logic [BYTE_W-1:0] nbr;
    if (i == MAX_PATTERN - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cur[i+1];
    end
    assign cell_sel[i]    = (fill_q == FILL_W'(i));
    assign cell_in_use[i] = LEN_W'(i) < plen;

    sfr_win_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (win_ctl),
      .sel_i       (cell_sel[i]),
      .text_byte_i (in_data_i.text_byte),
      .pat_byte_i  (pat_bytes_q[BYTE_W*i +: BYTE_W]),
      .in_use_i    (cell_in_use[i]),
      .nbr_i       (nbr),
      .cur_o       (cur[i]),
      .match_o     (cell_match[i])
    );
  end

  // ---- result count of this transaction
  // full window: replacement on a hit, else the oldest byte (and the rest on the
  // final transaction); otherwise only the final transaction flushes
  always_comb begin
    if (full) begin
      if (hit) begin
        n_raw = rlen;
      end else if (last) begin
        n_raw = plen;
      end else begin
        n_raw = LEN_W'(1);
      end
    end else if (last) begin
      n_raw = fill_ext + LEN_W'(1);
    end else begin
      n_raw = '0;
    end
  end

  // final transaction with nothing to emit gives one empty end marker
  assign marker = last && (n_raw == '0);
  assign n_eff  = marker ? LEN_W'(1) : n_raw;

  for (genvar k = 0; k < NUM_RESULTS; k++) begin : g_load
    assign load_occ[k]                = LEN_W'(k) < n_eff;
    assign load_item[k].out_byte      = marker ? '0 :
                                        (hit ? rep_bytes_q[BYTE_W*k +: BYTE_W] : cur[k]);
    assign load_item[k].byte_valid    = !marker;
    assign load_item[k].end_of_output = last && (LEN_W'(k) == n_eff - LEN_W'(1));
  end

  // ---- result queue row: drains one entry per cycle into the output register while it is not stalled
  assign head_move    = occ[0] && (!out_valid_q || out_ready_i);
  assign oq_ctl.load  = in_acc;
  assign oq_ctl.shift = head_move;

  // take a transaction once the queue is empty or its last entry leaves now
  assign in_ready_o = !occ[0] || (!occ[1] && head_move);

  for (genvar k = 0; k < NUM_RESULTS; k++) begin : g_oq
    logic      nbr_occ;
    text_out_t nbr_item;
    if (k == NUM_RESULTS - 1) begin : g_tail
      assign nbr_occ  = 1'b0;
      assign nbr_item = '0;
    end else begin : g_mid
      assign nbr_occ  = occ[k+1];
      assign nbr_item = item[k+1];
    end

    sfr_out_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (oq_ctl),
      .load_occ_i  (load_occ[k]),
      .load_item_i (load_item[k]),
      .nbr_occ_i   (nbr_occ),
      .nbr_item_i  (nbr_item),
      .occ_o       (occ[k]),
      .item_o      (item[k])
    );
  end

  // ---- window fill
  always_comb begin
    fill_d = fill_q;
    if (in_acc) begin
      if (last || hit) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
    // a new pattern length drops the pending bytes
    if (cfg_acc && (cfg_index_i == REG_PATTERN_LENGTH)) begin
      fill_d = '0;
    end
  end

  // ---- output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (head_move) begin
      out_valid_d = 1'b1;
      out_d       = item[0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LEN_W'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_PATTERN_BYTES:      pat_bytes_q <= cfg_data_i;
          REG_PATTERN_LENGTH:     pat_len_q   <= cfg_data_i[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data_i;
          REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- checks

  // queue occupancy stays contiguous from the head
  a_occ_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ >> 1) & ~occ) == '0)
    else $error("result queue has a gap");

  // pending bytes never reach the pattern length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_ext < plen)
    else $error("window fill at or above pattern length");

  // the final transaction leaves the window empty
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> fill_q == '0)
    else $error("window not flushed after final transaction");

  // an empty result is only ever the end marker
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.end_of_output && (out_data_o.out_byte == '0))
    else $error("empty result that is not an end marker");

endmodule

// ===== verif/sfr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfr_checker
// watches the text, result and configuration channels of the find-and-replace
// block, works out every result it should give and compares them in order
// ----------------------------------------------------------------------------
module sfr_checker import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  text_in_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  text_out_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          due_count_o
);

  // mirror of the block's pending window and registers
  logic [BYTE_W-1:0] held_text [MAX_PATTERN];
  int unsigned       held_fill;
  logic [WORD_W-1:0] pattern_word;
  logic [LEN_W-1:0]  pattern_len;
  logic [WORD_W-1:0] replace_word;
  logic [LEN_W-1:0]  replace_len;

  text_out_t due_bytes [$];
  text_out_t oldest;

  initial mismatch_count_o = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < 40) $display("%0t: %s", $time, what);
    mismatch_count_o++;
  endtask

  // one text transaction: append, compare the full window, then flush on the last
  task automatic find_replace_step(input text_in_t item);
    int unsigned plen;
    int unsigned rlen;
    bit          hit;
    text_out_t   burst [$];
    plen = (pattern_len == 0) ? 1 : (pattern_len > MAX_PATTERN) ? MAX_PATTERN : pattern_len;
    rlen = (replace_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : replace_len;
    if (held_fill >= plen) held_fill = 0;
    held_text[held_fill] = item.text_byte;
    held_fill++;
    if (held_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (held_text[i] != pattern_word[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) burst.push_back('{replace_word[8*i +: 8], 1'b1, 1'b0});
        held_fill = 0;
      end else begin
        burst.push_back('{held_text[0], 1'b1, 1'b0});
        for (int i = 1; i < held_fill; i++) held_text[i-1] = held_text[i];
        held_fill--;
      end
    end
    if (item.end_of_text) begin
      for (int i = 0; i < held_fill; i++) burst.push_back('{held_text[i], 1'b1, 1'b0});
      held_fill = 0;
      // nothing left to say: an empty end marker
      if (burst.size() == 0) burst.push_back('{'0, 1'b0, 1'b0});
      burst[burst.size()-1].end_of_output = 1'b1;
    end
    foreach (burst[k]) due_bytes.push_back(burst[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERN; i++) held_text[i] = '0;
      held_fill    = 0;
      pattern_word = '0;
      pattern_len  = LEN_W'(1);
      replace_word = '0;
      replace_len  = '0;
      due_bytes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing due", out_data_i));
        end else begin
          oldest = due_bytes.pop_front();
          if (out_data_i.out_byte !== oldest.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_data_i.out_byte, oldest.out_byte));
          if (out_data_i.byte_valid !== oldest.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      out_data_i.byte_valid, oldest.byte_valid));
          if (out_data_i.end_of_output !== oldest.end_of_output)
            report_mismatch($sformatf("end_of_output %b, expected %b",
                                      out_data_i.end_of_output, oldest.end_of_output));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PATTERN_BYTES: pattern_word = cfg_data_i;
          REG_PATTERN_LENGTH: begin
            pattern_len = cfg_data_i[LEN_W-1:0];
            held_fill   = 0;
          end
          REG_REPLACEMENT_BYTES: replace_word = cfg_data_i;
          REG_REPLACEMENT_LENGTH: replace_len = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) find_replace_step(in_data_i);
    end
    due_count_o = due_bytes.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives text and settings into the find-and-replace block with random
// gaps and stalls on both sides; the checker beside it judges every result
// ----------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  localparam int unsigned CLK_PERIOD       = 12;
  localparam int unsigned RESET_CYCLES     = 5;
  // the block may still be busy with a transaction that gives no result
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS      = 21;
  localparam longint unsigned RUN_LIMIT_NS = 3_000_000;
  // first index past the register list, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd4;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  text_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  text_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0]    cfg_data_i  = '0;

  int unsigned mismatch_count;
  int unsigned due_count;

  // idling spans, redrawn now and then so that some stretches run flat out
  int unsigned in_gap_span  = 15;
  int unsigned out_gap_span = 15;
  int unsigned texts_sent   = 0;
  // asks the result side for one long stall
  bit          hold_request = 1'b0;

  stream_find_replace uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sfr_checker result_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i (in_ready_o), .in_data_i,
    .out_valid_i (out_valid_o), .out_ready_i, .out_data_i (out_data_o),
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o (mismatch_count),
    .due_count_o      (due_count)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // first character in bits 7..0
  function automatic logic [WORD_W-1:0] pack_text(input string s);
    logic [WORD_W-1:0] word;
    word = '0;
    for (int i = 0; i < s.len() && i < 8; i++) word[8*i +: 8] = s[i];
    return word;
  endfunction

  // one text transaction; valid stays up straight into the next one when
  // no gap is drawn
  task automatic send_text(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    gap = $urandom_range(in_gap_span, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{text_byte: b, end_of_text: last};
    do @(posedge clk_i); while (!in_ready_o);
    texts_sent++;
    if (texts_sent % 16 == 0) in_gap_span = ($urandom_range(3, 0) == 0) ? 0 : 15;
  endtask

  task automatic send_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_text(s[i], close && (i == s.len() - 1));
  endtask

  // stop offering text, then wait for every due result and a further settling wait
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // full register set, then a write past the list that must change nothing;
  // length writes carry random upper bits, only the low nibble counts
  task automatic set_up_search(input logic [WORD_W-1:0] pat_word,
                               input logic [LEN_W-1:0]  pat_code,
                               input logic [WORD_W-1:0] rep_word,
                               input logic [LEN_W-1:0]  rep_code);
    logic [WORD_W-1:0] noise;
    wait_idle();
    noise = {$urandom, $urandom};
    write_reg(REG_PATTERN_BYTES, pat_word);
    write_reg(REG_PATTERN_LENGTH, {noise[WORD_W-1:LEN_W], pat_code});
    write_reg(REG_REPLACEMENT_BYTES, rep_word);
    write_reg(REG_REPLACEMENT_LENGTH, {noise[LEN_W +: WORD_W-LEN_W], rep_code});
    write_reg(CFG_IDX_W'($urandom_range(255, REG_FIRST_UNUSED)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stalls per transaction, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          hold_done;
    taken     = 0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(out_gap_span, 0);
      if (hold_request && !hold_done) begin
        // long stall so the block fills and pushes back on the text side
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 16 == 0) out_gap_span = ($urandom_range(3, 0) == 0) ? 0 : 15;
    end
  end

  initial begin : text_source
    logic [BYTE_W-1:0] alphabet [3];
    logic [WORD_W-1:0] pat_word;
    logic [LEN_W-1:0]  pat_code;
    logic [LEN_W-1:0]  rep_code;
    int unsigned       pat_eff;
    int unsigned       pieces;
    int unsigned       pick;
    int unsigned       cut;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: the single character 00 is replaced by nothing
    send_text(8'h00, 1'b1);   // whole text deleted, only the empty end marker
    send_text(8'h00, 1'b0);   // deleted mid-text, no result at all
    send_text(8'hff, 1'b1);

    // two-character pattern, longer replacement, a near miss before a hit
    set_up_search(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3);
    send_string("abaab", 1'b0);
    send_string("cxa", 1'b1);   // misses, then a pending byte flushed

    // pattern length rewritten while a byte is pending: that byte is dropped
    send_text("a", 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    cfg_valid_i <= 1'b0;
    send_text("b", 1'b1);

    // length zero acts as one, replacement length above the limit saturates
    set_up_search('1, 4'd0, 64'h0123_4567_89ab_cdef, 4'd15);
    send_text(8'hff, 1'b0);
    send_text(8'h00, 1'b1);

    // pattern length above the limit saturates, match deleted outright
    set_up_search(pack_text("abcdefgh"), 4'd15, '1, 4'd0);
    send_string("abcdefgh", 1'b0);
    send_text("z", 1'b1);

    // random phases: patterns over a tiny alphabet so that near misses and
    // back-to-back hits are common, with some plain noise in between
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(255, 0));
      pat_word = {$urandom, $urandom};
      for (int j = 0; j < 8; j++) pat_word[8*j +: 8] = alphabet[$urandom_range(2, 0)];
      if (phase == 0) begin
        pat_code = 4'd8;
        rep_code = 4'd8;
      end else begin
        pat_code = LEN_W'(($urandom_range(4, 0) == 0) ? $urandom_range(15, 0)
                                                       : $urandom_range(8, 1));
        rep_code = LEN_W'(($urandom_range(4, 0) == 0) ? $urandom_range(15, 0)
                                                       : $urandom_range(8, 0));
      end
      pat_eff = (pat_code == 0) ? 1 : (pat_code > 8) ? 8 : pat_code;
      set_up_search(pat_word, pat_code, {$urandom, $urandom}, rep_code);
      if (phase == 1) hold_request = 1'b1;

      pieces = 0;
      while (pieces < PHASE_ITEMS) begin
        pick = $urandom_range(9, 0);
        if (pick < 6) begin
          // whole pattern, or a broken prefix of it
          cut = (pick < 4) ? pat_eff : $urandom_range(pat_eff, 1);
          for (int j = 0; j < cut; j++)
            send_text(pat_word[8*j +: 8], $urandom_range(11, 0) == 0);
          pieces += cut;
        end else begin
          send_text((pick < 9) ? alphabet[$urandom_range(2, 0)] : 8'($urandom_range(255, 0)),
                    $urandom_range(11, 0) == 0);
          pieces++;
        end
      end
      send_text(8'($urandom_range(255, 0)), 1'b1);
    end

    wait_idle();
    if (mismatch_count == 0 && due_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
